### rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Opcodes, status codes and value width shared by the stack calculator files.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int VAL_W = 48;

  localparam logic [3:0] OP_PUSH  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_REM   = 4'd5;
  localparam logic [3:0] OP_DUP   = 4'd6;
  localparam logic [3:0] OP_SWAP  = 4'd7;
  localparam logic [3:0] OP_TOP   = 4'd8;
  localparam logic [3:0] OP_CLEAR = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_DUP_EMPTY = 3'd2;
  localparam logic [2:0] ST_SWAP_LOW = 3'd3;
  localparam logic [2:0] ST_REM_ZERO = 3'd4;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

### rtl/rsc_div.sv
// ----------------------------------------------------------------------------
// rsc_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module rsc_div #(
  parameter int DW = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DW-1:0]           dividend,
  input  logic [rsc_pkg::VAL_W-1:0] divisor,
  output logic                    done,
  output logic [DW-1:0]           quotient,
  output logic [rsc_pkg::VAL_W-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);
  localparam int VW = rsc_pkg::VAL_W;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] num;
  logic [VW-1:0] rem;
  logic [VW-1:0] den;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, num[DW-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
        num <= {num[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = num;
  assign remainder = rem;

endmodule

### rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator over a bounded stack of signed Q31.16 values.
// ----------------------------------------------------------------------------
// Input words on s_* carry an opcode and a push value; every accepted word
// returns one result word on m_* with the new top, the depth and a status.
// The stack lives in a one-port-read, one-port-write synchronous memory; the
// top entry is mirrored in a register so only the second operand is read.
// One word is processed at a time:
//   push, dup, top, clear, add, sub: S_EXEC, then S_FIN to the result
//   swap: S_EXEC, S_SWAP2, then S_FIN (two memory writes)
//   mul: S_EXEC, S_MUL for the bit-serial shift-add multiplier, then S_FIN
//   div, rem: S_EXEC, S_DIV waiting on the restoring divider, then S_FIN
// A new word is taken once the previous one has been moved into the output
// register, so a result waiting on m_tready overlaps the next accept; a
// stalled receiver holds the block only when a second result is ready.
// Reset empties the stack (depth zero) and clears m_tvalid; the
// memory contents need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // opcode[3:0], operand_value[51:4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((rsc_pkg::VAL_W + $clog2(STACK_DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0]
                      m_tdata    // top_value, depth, status
);

  localparam int VW    = rsc_pkg::VAL_W;
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int DEPW  = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W = ((VW + DEPW + 3 + 7) / 8) * 8;
  localparam int DW    = VW + FRAC_BITS;
  localparam int PW    = 2 * VW;
  localparam int MCW   = $clog2(VW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SWAP2 = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

  function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [PW-1:0] mag);
    logic [VW-1:0] r;
    if (neg) begin
      r = (mag >= PW'(MINV)) ? MINV : (VW'(0) - mag[VW-1:0]);
    end else begin
      r = (mag > PW'(MAXV)) ? MAXV : mag[VW-1:0];
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] sat_sum(input logic [VW:0] s);
    logic [VW-1:0] r;
    if (s[VW] != s[VW-1]) begin
      r = s[VW] ? MINV : MAXV;
    end else begin
      r = s[VW-1:0];
    end
    return r;
  endfunction

  logic [VW-1:0] mem [STACK_DEPTH];
  logic [VW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  logic [2:0]      state, state_next;
  logic [3:0]      op, op_next;
  logic [VW-1:0]   val, val_next;
  logic [DEPW-1:0] depth, depth_next;
  logic [VW-1:0]   tos, tos_next;
  logic [VW-1:0]   opa, opa_next;
  logic            neg, neg_next;
  logic [PW-1:0]   mp, mp_next;
  logic [MCW-1:0]  mcnt, mcnt_next;
  logic [2:0]      status, status_next;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [VW-1:0] div_rem;

  logic [DEPW-1:0] dm2;
  logic [DEPW-1:0] base;
  logic [VW-1:0]   a, b, ma, mb, ib, rres;
  logic [VW:0]     msum;
  logic            push_en;
  logic [VW-1:0]   push_val;

  assign dm2     = depth - DEPW'(2);
  assign rd_addr = dm2[AW-1:0];
  assign base    = (depth >= DEPW'(2)) ? dm2 : DEPW'(0);
  assign a       = (depth >= DEPW'(2)) ? rd_data : '0;
  assign b       = (depth != '0) ? tos : '0;
  assign ma      = a[VW-1] ? (VW'(0) - a) : a;
  assign mb      = b[VW-1] ? (VW'(0) - b) : b;
  assign ib      = mb >> FRAC_BITS;
  assign msum    = {1'b0, mp[PW-1:VW]} + (mp[0] ? {1'b0, opa} : '0);
  assign rres    = div_rem << FRAC_BITS;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  rsc_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next   = state;
    op_next      = op;
    val_next     = val;
    depth_next   = depth;
    tos_next     = tos;
    opa_next     = opa;
    neg_next     = neg;
    mp_next      = mp;
    mcnt_next    = mcnt;
    status_next  = status;
    wr_en        = 1'b0;
    wr_addr      = depth[AW-1:0];
    wr_data      = val;
    div_start    = 1'b0;
    div_dividend = DW'(ma) << FRAC_BITS;
    div_divisor  = b;
    push_en      = 1'b0;
    push_val     = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next     = s_tdata[3:0];
          val_next    = s_tdata[VW+3:4];
          status_next = rsc_pkg::ST_OK;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        case (op)
          rsc_pkg::OP_PUSH: begin
            if (depth < DEPW'(STACK_DEPTH)) begin
              wr_en      = 1'b1;
              wr_data    = val;
              tos_next   = val;
              depth_next = depth + DEPW'(1);
            end else begin
              status_next = rsc_pkg::ST_OVERFLOW;
            end
          end
          rsc_pkg::OP_ADD: begin
            push_en  = 1'b1;
            push_val = sat_sum({a[VW-1], a} + {b[VW-1], b});
          end
          rsc_pkg::OP_SUB: begin
            push_en  = 1'b1;
            push_val = sat_sum({a[VW-1], a} - {b[VW-1], b});
          end
          rsc_pkg::OP_MUL: begin
            opa_next   = ma;
            mp_next    = PW'(mb);
            neg_next   = a[VW-1] ^ b[VW-1];
            mcnt_next  = MCW'(VW);
            state_next = S_MUL;
          end
          rsc_pkg::OP_DIV: begin
            // divisor that is not positive becomes one
            div_divisor = (b[VW-1] || b == '0) ? (VW'(1) << FRAC_BITS) : b;
            div_start   = 1'b1;
            neg_next    = a[VW-1];
            state_next  = S_DIV;
          end
          rsc_pkg::OP_REM: begin
            if (ib == '0) begin
              status_next = rsc_pkg::ST_REM_ZERO;
              push_en     = 1'b1;
            end else begin
              div_dividend = DW'(ma >> FRAC_BITS);
              div_divisor  = ib;
              div_start    = 1'b1;
              neg_next     = a[VW-1];
              state_next   = S_DIV;
            end
          end
          rsc_pkg::OP_DUP: begin
            if (depth == '0) begin
              status_next = rsc_pkg::ST_DUP_EMPTY;
            end else if (depth >= DEPW'(STACK_DEPTH)) begin
              status_next = rsc_pkg::ST_OVERFLOW;
            end else begin
              wr_en      = 1'b1;
              wr_data    = tos;
              depth_next = depth + DEPW'(1);
            end
          end
          rsc_pkg::OP_SWAP: begin
            if (depth < DEPW'(2)) begin
              status_next = rsc_pkg::ST_SWAP_LOW;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = dm2[AW-1:0];
              wr_data    = tos;
              opa_next   = rd_data;
              tos_next   = rd_data;
              state_next = S_SWAP2;
            end
          end
          rsc_pkg::OP_CLEAR: begin
            depth_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        if (mcnt == '0) begin
          push_en    = 1'b1;
          push_val   = sat_mag(neg, mp >> FRAC_BITS);
          state_next = S_FIN;
        end else begin
          mp_next   = {msum, mp[VW-1:1]};
          mcnt_next = mcnt - MCW'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          push_en    = 1'b1;
          state_next = S_FIN;
          if (op == rsc_pkg::OP_DIV) begin
            push_val = sat_mag(neg, PW'(div_quo));
          end else begin
            push_val = neg ? (VW'(0) - rres) : rres;
          end
        end
      end
      S_SWAP2: begin
        wr_en      = 1'b1;
        wr_addr    = AW'(depth - DEPW'(1));
        wr_data    = opa;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // pop two operands, push the result
    if (push_en) begin
      wr_en      = 1'b1;
      wr_addr    = base[AW-1:0];
      wr_data    = push_val;
      tos_next   = push_val;
      depth_next = base + DEPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_W'({status, depth, (depth != '0) ? tos : VW'(0)});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    op     <= op_next;
    val    <= val_next;
    tos    <= tos_next;
    opa    <= opa_next;
    neg    <= neg_next;
    mp     <= mp_next;
    mcnt   <= mcnt_next;
    status <= status_next;
  end

endmodule

### rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks for the stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker #(
  parameter int STACK_DEPTH = 1024,
  parameter int DEPW        = 11,
  parameter int OUT_W       = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int VW = rsc_pkg::VAL_W;

  logic [DEPW-1:0] o_depth;
  logic [2:0]      o_status;
  logic [VW-1:0]   o_top;

  assign o_top    = m_tdata[VW-1:0];
  assign o_depth  = m_tdata[VW+DEPW-1:VW];
  assign o_status = m_tdata[VW+DEPW+2:VW+DEPW];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_depth <= DEPW'(STACK_DEPTH))
    else $error("depth beyond stack size");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_depth == '0 |-> o_top == '0)
    else $error("empty stack with nonzero top");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status == rsc_pkg::ST_OVERFLOW |-> o_depth == DEPW'(STACK_DEPTH))
    else $error("overflow reported below full");

  a_status_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_status == rsc_pkg::ST_DUP_EMPTY || o_status == rsc_pkg::ST_SWAP_LOW)
      |-> o_depth < DEPW'(2))
    else $error("dup or swap error with enough entries");

endmodule

bind rpn_stack_calculator rsc_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .DEPW        ($clog2(STACK_DEPTH + 1)),
  .OUT_W       (((rsc_pkg::VAL_W + $clog2(STACK_DEPTH + 1) + 3 + 7) / 8) * 8)
) u_rsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
